[src/binary_max_heap_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the binary max-heap
// Concurrent assertion shorthands, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_ASSERT_SVH
`define BINARY_MAX_HEAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bmh_pkg.sv]
// ---------------------------------------------------------------------------
// Binary max-heap package
// Widths, default capacity, opcodes and status codes shared by the heap modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmh_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_WIDTH      = 32;
   localparam int STATUS_WIDTH     = 2;
   localparam int TOTAL_WIDTH      = 5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

endpackage

[src/bmh_store.sv]
// ---------------------------------------------------------------------------
// Binary max-heap element store
// Synchronous memory with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmh_store #(
   parameter int DEPTH      = bmh_pkg::DEFAULT_CAPACITY,
   parameter int ADDR_WIDTH = $clog2(bmh_pkg::DEFAULT_CAPACITY),
   parameter int DATA_WIDTH = bmh_pkg::VALUE_WIDTH
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_WIDTH-1:0]        wr_addr,
   input  logic signed [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0]        rd_addr_a,
   input  logic [ADDR_WIDTH-1:0]        rd_addr_b,
   output logic signed [DATA_WIDTH-1:0] rd_data_a,
   output logic signed [DATA_WIDTH-1:0] rd_data_b
);

   logic signed [DATA_WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

[src/binary_max_heap.sv]
// ---------------------------------------------------------------------------
// Binary max-heap priority queue
// Bounded max-heap of signed values held in a synchronous memory, with push
// and pop-maximum commands and one result per command.
// ---------------------------------------------------------------------------
//  Channel   Ports                                         Transfer
//  request   start, busy, req_opcode, req_value            start && !busy
//  response  rsp_strobe, rsp_popped_value, rsp_status,     rsp_strobe
//            rsp_element_total, rsp_heap_empty
//
//  A rejected command answers in the cycle after its transfer. A push climbs
//  with a parent read (S_UP) and a compare-and-write (S_UP_CMP) per level; a
//  pop reads the root and the last element (S_POP), then per level the children
//  (S_DN) and a compare-and-write (S_DN_CMP).
//  Reset clears the element count; the memory needs no clearing.
//  The receiver cannot stall: each result is shown for one cycle only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_max_heap_assert.svh"

module binary_max_heap #(
   parameter int CAPACITY = bmh_pkg::DEFAULT_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic signed [bmh_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                  rsp_strobe,
   output logic signed [bmh_pkg::VALUE_WIDTH-1:0] rsp_popped_value,
   output logic [bmh_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [bmh_pkg::TOTAL_WIDTH-1:0]       rsp_element_total,
   output logic                                  rsp_heap_empty
);

   import bmh_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_UP     = 6'b000010,
      S_UP_CMP = 6'b000100,
      S_POP    = 6'b001000,
      S_DN     = 6'b010000,
      S_DN_CMP = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic signed [VALUE_WIDTH-1:0] val_ff, val_in;
   logic signed [VALUE_WIDTH-1:0] popped_ff, popped_in;
   logic                      strobe_ff, strobe_in;
   logic [STATUS_WIDTH-1:0]   status_ff, status_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]             rd_addr_a, rd_addr_b;
   logic signed [VALUE_WIDTH-1:0] rd_data_a, rd_data_b;

   logic                      accept;
   logic [XW-1:0]             left_idx, right_idx, count_x;
   logic                      left_ok, right_ok, take_left, take_right;
   logic signed [VALUE_WIDTH-1:0] best_val;
   logic [AW-1:0]             parent_idx;
   logic [CW-1:0]             last_idx;

   bmh_store #(
      .DEPTH      (CAPACITY),
      .ADDR_WIDTH (AW),
      .DATA_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign accept     = start && (state_ff == S_IDLE);
   assign count_x    = XW'(count_ff);
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = left_idx + XW'(1);
   assign left_ok    = left_idx < count_x;
   assign right_ok   = left_ok && (right_idx < count_x);
   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign last_idx   = count_ff - CW'(1);
   assign take_left  = rd_data_a > val_ff;
   assign best_val   = take_left ? rd_data_a : val_ff;
   assign take_right = right_ok && (rd_data_b > best_val);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      popped_in = popped_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = val_ff;
      rd_addr_a = '0;
      rd_addr_b = last_idx[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = ST_DONE;
               if (req_opcode == OP_PUSH) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     strobe_in = 1'b1;
                  end else begin
                     pos_in   = count_ff[AW-1:0];
                     val_in   = req_value;
                     count_in = count_ff + CW'(1);
                     state_in = S_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     strobe_in = 1'b1;
                  end else begin
                     count_in = last_idx;
                     state_in = S_POP;
                  end
               end
            end
         end
         S_UP: begin
            rd_addr_a = parent_idx;
            if (pos_ff == '0) begin
               wr_en     = 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (val_ff > rd_data_a) begin
               wr_data  = rd_data_a;
               pos_in   = parent_idx;
               state_in = S_UP;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_POP: begin
            popped_in = rd_data_a;
            val_in    = rd_data_b;
            pos_in    = '0;
            state_in  = S_DN;
         end
         S_DN: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
            if (left_ok) begin
               state_in = S_DN_CMP;
            end else begin
               wr_en     = 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            priority if (take_right) begin
               wr_data  = rd_data_b;
               pos_in   = right_idx[AW-1:0];
               state_in = S_DN;
            end else if (take_left) begin
               wr_data  = rd_data_a;
               pos_in   = left_idx[AW-1:0];
               state_in = S_DN;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_popped_value  = popped_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_total = TOTAL_WIDTH'(count_ff);
   assign rsp_heap_empty    = (count_ff == '0);

   `BMH_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
      "Element count exceeds the capacity.")
   `BMH_ASSERT_NEXT(a_full_reject, clock, reset,
      accept && (req_opcode == OP_PUSH) && (count_ff == CW'(CAPACITY)),
      rsp_strobe && (rsp_status == ST_FULL),
      "Push on a full heap was not rejected in the next cycle.")
   `BMH_ASSERT_NEXT(a_pop_count, clock, reset,
      accept && (req_opcode == OP_POP) && (count_ff != '0),
      count_ff == $past(count_ff) - CW'(1),
      "Accepted pop did not decrement the element count.")
   `BMH_ASSERT_SAME(a_write_busy, clock, reset, wr_en, busy,
      "Memory written while the heap is idle.")

endmodule
